/* design/mf3_pkg.sv */
package mf3_pkg;

  // Sample and geometry limits
  localparam int CHANNEL_BITS = 8;
  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 4095;
  localparam int MIN_DIM = 3;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WIDTH_W = COL_W + 1;
  localparam int ROW_W = 12;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
  localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);

  typedef enum logic {
    REG_IMAGE_WIDTH = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pix_t;

  typedef struct packed {
    chan_t in_red;
    chan_t in_green;
    chan_t in_blue;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    logic frame_last;
  } out_item_t;

  // Effective frame geometry after clamping
  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [ROW_W-1:0] height;
  } geom_t;

  // Line buffer access for one item
  typedef struct packed {
    logic rd_en;
    logic [COL_W-1:0] rd_addr;
    logic wr_en;
    logic [COL_W-1:0] wr_addr;
  } lb_ctl_t;

  // Position data that travels alongside an item
  typedef struct packed {
    logic emit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic last;
  } meta_t;

endpackage

/* design/mf3_cfg.sv */
module mf3_cfg
  import mf3_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output geom_t              geom
);

  logic [WIDTH_W-1:0] image_width;
  logic [ROW_W-1:0]   image_height;
  reg_idx_t           idx;
  logic               wr;

  assign idx = reg_idx_t'(paddr[2]);
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_IMAGE_WIDTH:  image_width <= pwdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[ROW_W-1:0];
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(image_height);
    endcase
  end

  // Clamp geometry to the supported range
  always_comb begin
    priority if (image_width < WIDTH_W'(MIN_DIM)) geom.width = WIDTH_W'(MIN_DIM);
    else if (image_width > WIDTH_W'(MAX_WIDTH)) geom.width = WIDTH_W'(MAX_WIDTH);
    else geom.width = image_width;

    priority if (image_height < ROW_W'(MIN_DIM)) geom.height = ROW_W'(MIN_DIM);
    else if (image_height > ROW_W'(MAX_HEIGHT)) geom.height = ROW_W'(MAX_HEIGHT);
    else geom.height = image_height;
  end

endmodule

/* design/mf3_line_buf.sv */
module mf3_line_buf
  import mf3_pkg::*;
(
  input  logic    clk,
  input  lb_ctl_t ctl,
  input  pix_t    wr_pix,
  output pix_t    upper_q,
  output pix_t    middle_q
);

  pix_t upper_mem [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];

  // Read both lines for the incoming item
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      upper_q <= upper_mem[ctl.rd_addr];
      middle_q <= middle_mem[ctl.rd_addr];
    end
  end

  // Move the middle line up and store the new pixel
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      upper_mem[ctl.wr_addr] <= middle_q;
      middle_mem[ctl.wr_addr] <= wr_pix;
    end
  end

endmodule

/* design/mf3_median.sv */
module mf3_median
  import mf3_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [8:0][CHANNEL_BITS-1:0] win,
  output chan_t            med
);

  function automatic chan_t min2(chan_t a, chan_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic chan_t max2(chan_t a, chan_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic chan_t med3(chan_t a, chan_t b, chan_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Sorted rows: [row][0]=low, [1]=mid, [2]=high
  logic [2:0][2:0][CHANNEL_BITS-1:0] srt;
  logic [2:0][2:0][CHANNEL_BITS-1:0] srt_next;
  chan_t lo_max, mid_med, hi_min;

  // Sort each row of three
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      srt_next[i][0] = min2(min2(win[3*i], win[3*i+1]), win[3*i+2]);
      srt_next[i][1] = med3(win[3*i], win[3*i+1], win[3*i+2]);
      srt_next[i][2] = max2(max2(win[3*i], win[3*i+1]), win[3*i+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) srt <= srt_next;
  end

  // Combine: largest low, middle mid, smallest high
  assign lo_max = max2(max2(srt[0][0], srt[1][0]), srt[2][0]);
  assign mid_med = med3(srt[0][1], srt[1][1], srt[2][1]);
  assign hi_min = min2(min2(srt[0][2], srt[1][2]), srt[2][2]);

  always_ff @(posedge clk) begin
    if (en) med <= med3(lo_max, mid_med, hi_min);
  end

endmodule

/* design/median_filter_3x3_rgb_top.sv */
// Streaming 3x3 median filter for RGB pixels in raster order. The block takes
// one pixel per clock and, for every interior pixel, returns one result per
// clock carrying the per-channel median of its 3x3 neighborhood, its row and
// column, and frame_last on the last interior pixel. Border pixels give no
// result. Each result passes, after its completing pixel is accepted (input
// register loaded and line buffers read at the accepting edge), through window
// shift, row sort and final merge to res; the rate is one item per cycle, limited
// only by res_ready back-pressure, which stalls the whole pipeline. The two
// previous lines live in two memories of 1024 x 24 bits with registered reads;
// they need no clearing after reset.
// Geometry is set through image_width (byte address 0) and image_height
// (byte address 4), clamped to 3..1024 and 3..4095, and may be changed only
// while the block is idle.
module median_filter_3x3_rgb_top
  import mf3_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               pix_valid,
  output logic               pix_ready,
  input  in_item_t           pix,
  output logic               res_valid,
  input  logic               res_ready,
  output out_item_t          res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  geom_t geom;
  logic adv, accept;
  logic [COL_W-1:0] col_count, col_next;
  logic [ROW_W-1:0] row_count, row_next;
  logic last_col, last_row;
  meta_t meta_next;

  logic s1_valid;
  meta_t s1_meta;
  pix_t s1_pix;
  logic [COL_W-1:0] s1_col;

  pix_t win [9];
  logic s2_valid;
  meta_t s2_meta;
  logic sa_valid;
  meta_t sa_meta;
  meta_t res_meta;

  lb_ctl_t lb_ctl;
  pix_t upper_q, middle_q;
  logic [8:0][CHANNEL_BITS-1:0] red_win, green_win, blue_win;
  chan_t red_med, green_med, blue_med;

  mf3_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom)
  );

  // Whole pipeline moves when the result register is free or being drained
  assign adv = !res_valid || res_ready;
  assign pix_ready = adv;
  assign accept = pix_valid && adv;

  // Position of the incoming pixel
  assign last_col = (WIDTH_W'(col_count) + WIDTH_W'(1)) >= geom.width;
  assign last_row = ((ROW_W + 1)'(row_count) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(geom.height);

  always_comb begin
    col_next = col_count + COL_W'(1);
    row_next = row_count;
    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : row_count + ROW_W'(1);
    end
    meta_next.emit = (row_count >= ROW_W'(2)) && (col_count >= COL_W'(2));
    meta_next.row = row_count - ROW_W'(1);
    meta_next.col = col_count - COL_W'(1);
    meta_next.last = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta_next;
      s1_col <= col_count;
      s1_pix <= '{red: pix.in_red, green: pix.in_green, blue: pix.in_blue};
    end
  end

  // Line buffers: read on accept, update when the item enters the window
  always_comb begin
    lb_ctl.rd_en = accept;
    lb_ctl.rd_addr = col_count;
    lb_ctl.wr_en = adv && s1_valid;
    lb_ctl.wr_addr = s1_col;
  end

  mf3_line_buf u_line_buf (
    .clk      (clk),
    .ctl      (lb_ctl),
    .wr_pix   (s1_pix),
    .upper_q  (upper_q),
    .middle_q (middle_q)
  );

  // Shift the 3x3 window one column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (adv && s1_valid) begin
      for (int k = 0; k < 3; k++) begin
        win[3*k] <= win[3*k+1];
        win[3*k+1] <= win[3*k+2];
      end
      win[2] <= upper_q;
      win[5] <= middle_q;
      win[8] <= s1_pix;
    end
  end

  // Track which items produce results through the median stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      sa_valid <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_meta.emit;
      sa_valid <= s2_valid;
      res_valid <= sa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_meta <= s1_meta;
      sa_meta <= s2_meta;
      res_meta <= sa_meta;
    end
  end

  // Split the window per channel
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      red_win[i] = win[i].red;
      green_win[i] = win[i].green;
      blue_win[i] = win[i].blue;
    end
  end

  mf3_median u_med_red (
    .clk (clk),
    .en  (adv),
    .win (red_win),
    .med (red_med)
  );

  mf3_median u_med_green (
    .clk (clk),
    .en  (adv),
    .win (green_win),
    .med (green_med)
  );

  mf3_median u_med_blue (
    .clk (clk),
    .en  (adv),
    .win (blue_win),
    .med (blue_med)
  );

  // Result register fields
  always_comb begin
    res.out_row = res_meta.row;
    res.out_col = res_meta.col;
    res.out_red = red_med;
    res.out_green = green_med;
    res.out_blue = blue_med;
    res.frame_last = res_meta.last;
  end

  // A line buffer entry is never read and written in the same cycle
  a_lb_no_collision: assert property (@(posedge clk) disable iff (rst)
    (lb_ctl.rd_en && lb_ctl.wr_en) |-> (lb_ctl.rd_addr != lb_ctl.wr_addr))
    else $error("line buffer read and write hit the same column");

  // The end of a line returns the column counter to zero
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && last_col) |=> (col_count == '0))
    else $error("column counter did not wrap at end of line");

  // Results never describe a pixel in the first row or the first column
  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.out_row != '0) && (res.out_col != '0)))
    else $error("result for a border pixel");

  // Only items that carried a full neighborhood reach the median stages
  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_valid && !s1_meta.emit) |=> !s2_valid)
    else $error("border item entered the median pipeline");

endmodule

/* tb/sv/median_filter_3x3_rgb_top_test.sv */
`timescale 1ns / 1ps

module median_filter_3x3_rgb_top_test;
  import mf3_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 560;
  localparam int LIMIT_CYCLES = 1_000_000;

  typedef enum int {
    PHASE_FULL,
    PHASE_PAUSE,
    PHASE_RECONFIG
  } phase_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_TIES,
    FILL_EXTREMES
  } fill_t;

  // Streaming 3x3 median predictor and store of expected medians
  class median_tracker;
    pix_t upper_line[MAX_WIDTH];
    pix_t middle_line[MAX_WIDTH];
    pix_t window[9];
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [WIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    out_item_t pending_medians[$];
    int errors;
    int pixels_seen;
    int medians_checked;
    int frames_done;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col = '0;
      row = '0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      errors = 0;
      pixels_seen = 0;
      medians_checked = 0;
      frames_done = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = value[WIDTH_W-1:0];
      end else begin
        height_reg = value[ROW_W-1:0];
      end
    endfunction

    function int unsigned eff_width();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_height();
      if (height_reg < MIN_DIM) return MIN_DIM;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return 32'(height_reg);
    endfunction

    function bit at_frame_start();
      return col == 0 && row == 0;
    endfunction

    function int pending();
      return pending_medians.size();
    endfunction

    // Insertion sort, take the middle sample
    function chan_t median9(chan_t s[9]);
      chan_t v;
      int j;
      for (int i = 1; i < 9; i++) begin
        v = s[i];
        j = i;
        while (j > 0 && s[j-1] > v) begin
          s[j] = s[j-1];
          j--;
        end
        s[j] = v;
      end
      return s[4];
    endfunction

    function void note_pixel(in_item_t p);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      pix_t px;
      chan_t reds[9];
      chan_t greens[9];
      chan_t blues[9];
      out_item_t e;
      logic last_col;
      logic last_row;
      w = eff_width();
      h = eff_height();
      c = 32'(col);
      r = 32'(row);
      px = {p.in_red, p.in_green, p.in_blue};
      // Slide the window left and pull in the new column
      for (int k = 0; k < 3; k++) begin
        window[k*3] = window[k*3+1];
        window[k*3+1] = window[k*3+2];
      end
      window[2] = upper_line[c];
      window[5] = middle_line[c];
      window[8] = px;
      upper_line[c] = middle_line[c];
      middle_line[c] = px;
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);
      // Interior pixel: expect a median for the center position
      if (r >= 2 && c >= 2) begin
        for (int i = 0; i < 9; i++) begin
          reds[i] = window[i].red;
          greens[i] = window[i].green;
          blues[i] = window[i].blue;
        end
        e.out_row = ROW_W'(r - 1);
        e.out_col = COL_W'(c - 1);
        e.out_red = median9(reds);
        e.out_green = median9(greens);
        e.out_blue = median9(blues);
        e.frame_last = last_col && last_row;
        pending_medians.push_back(e);
      end
      // Advance the raster position
      if (last_col) begin
        col = '0;
        row = last_row ? '0 : ROW_W'(r + 1);
      end else begin
        col = COL_W'(c + 1);
      end
      pixels_seen++;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_medians.size() == 0) begin
        $error("unexpected median item at row %0d col %0d", got.out_row, got.out_col);
        errors++;
        return;
      end
      want = pending_medians.pop_front();
      compare_field("out_row", 32'(want.out_row), 32'(got.out_row));
      compare_field("out_col", 32'(want.out_col), 32'(got.out_col));
      compare_field("out_red", 32'(want.out_red), 32'(got.out_red));
      compare_field("out_green", 32'(want.out_green), 32'(got.out_green));
      compare_field("out_blue", 32'(want.out_blue), 32'(got.out_blue));
      compare_field("frame_last", 32'(want.frame_last), 32'(got.frame_last));
      medians_checked++;
      if (want.frame_last) frames_done++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_ready;
  in_item_t pix = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  out_item_t res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  median_tracker sb;
  bit idle_on = 1'b0;
  int sink_wait = 0;
  int cycle_count = 0;
  int reg_writes = 0;

  median_filter_3x3_rgb_top DUT (
    .clk(clk),
    .rst(rst),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix(pix),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Check each accepted median item, then draw the next stall
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) begin
        sb.check_result(res);
        sink_wait = idle_on ? $urandom_range(0, 9) : 0;
      end
      if (sink_wait > 0) begin
        res_ready <= 1'b0;
        sink_wait--;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d medians outstanding",
               cycle_count, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_pixel(input in_item_t p);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix <= p;
    do @(posedge clk); while (!pix_ready);
    sb.note_pixel(p);
  endtask

  // Hold the sender until every expected median is out and the pipe is empty
  task automatic pause_until_drained();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, value);
    reg_writes++;
    @(posedge clk);
  endtask

  function automatic in_item_t draw_pixel(fill_t f);
    logic [3*CHANNEL_BITS-1:0] bits;
    for (int k = 0; k < 3; k++) begin
      case (f)
        FILL_TIES: begin
          bits[k*CHANNEL_BITS +: CHANNEL_BITS] = CHANNEL_BITS'(
            $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(252, 255));
        end
        FILL_EXTREMES: begin
          bits[k*CHANNEL_BITS +: CHANNEL_BITS] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        default: begin
          bits[k*CHANNEL_BITS +: CHANNEL_BITS] = CHANNEL_BITS'($urandom_range(0, 255));
        end
      endcase
    end
    return in_item_t'(bits);
  endfunction

  task automatic send_pixels(input int n, input fill_t f);
    repeat (n) send_pixel(draw_pixel(f));
  endtask

  task automatic finish_frame(input fill_t f);
    do send_pixel(draw_pixel(f)); while (!sb.at_frame_start());
  endtask

  in_item_t corner_pixels[9] = '{
    24'h000000, 24'hFFFFFF, 24'hAA550F, 24'h55AAF0, 24'hFF0080,
    24'h00FF7F, 24'h0180FE, 24'h8001FF, 24'h7FFE00
  };

  initial begin
    in_item_t p;
    int base;
    int draw;
    int k;
    int w_eff;
    int h_eff;
    phase_t kind;
    fill_t fill;

    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Smallest frame, both sizes below range: one median from corner-case samples
    idle_on = 1'($urandom_range(0, 1));
    write_reg(REG_IMAGE_WIDTH, 32'd0);
    write_reg(REG_IMAGE_HEIGHT, 32'd2);
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    pause_until_drained();

    // Four columns by three rows with ramps and repeats
    write_reg(REG_IMAGE_WIDTH, 32'd4);
    write_reg(REG_IMAGE_HEIGHT, 32'd3);
    for (int i = 0; i < 12; i++) begin
      p.in_red = 8'(255 - 21 * i);
      p.in_green = 8'((i % 3) * 127);
      p.in_blue = 8'(i * 23);
      send_pixel(p);
    end
    pause_until_drained();

    // Width above range clamps to the maximum, height to three; then shrink the line
    idle_on = 1'b0;
    write_reg(REG_IMAGE_WIDTH, 32'hFFFF_FFFF);
    write_reg(REG_IMAGE_HEIGHT, 32'hFFFF_F000);
    send_pixels(20, FILL_RANDOM);
    pause_until_drained();
    write_reg(REG_IMAGE_WIDTH, 32'd12);
    finish_frame(FILL_RANDOM);
    pause_until_drained();

    // Tallest height, then shrink both sizes mid-frame past the current position
    idle_on = 1'b1;
    write_reg(REG_IMAGE_WIDTH, 32'd5);
    write_reg(REG_IMAGE_HEIGHT, 32'd4095);
    send_pixels(23, FILL_RANDOM);
    pause_until_drained();
    write_reg(REG_IMAGE_HEIGHT, 32'd1);
    write_reg(REG_IMAGE_WIDTH, 32'd3);
    finish_frame(FILL_RANDOM);
    pause_until_drained();

    // Random frames with random geometry, content and idling
    base = sb.pixels_seen;
    while (sb.pixels_seen - base < RANDOM_ITEMS) begin
      draw = $urandom_range(0, 19);
      kind = (draw < 12) ? PHASE_FULL : (draw < 17) ? PHASE_RECONFIG : PHASE_PAUSE;
      draw = $urandom_range(0, 9);
      fill = (draw < 6) ? FILL_RANDOM : (draw < 8) ? FILL_TIES : FILL_EXTREMES;
      idle_on = ($urandom_range(0, 3) != 0);

      // Program geometry at the frame boundary
      draw = $urandom_range(0, 3);
      if (draw != 1 || sb.eff_width() > 40) begin
        k = $urandom_range(0, 19);
        w_eff = (k < 2) ? $urandom_range(0, 2) : (k == 2) ? $urandom_range(13, 40)
                                                           : $urandom_range(3, 12);
        write_reg(REG_IMAGE_WIDTH, {$urandom_range(0, 1) ? 21'h1FFFFF : 21'h0,
                                    11'(w_eff)});
      end
      if (draw != 0 || kind == PHASE_RECONFIG) begin
        k = $urandom_range(0, 9);
        if (kind == PHASE_RECONFIG) begin
          h_eff = (k < 3) ? 4095 : (k == 3) ? 2000 : $urandom_range(3, 8);
        end else begin
          h_eff = (k == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
        end
        write_reg(REG_IMAGE_HEIGHT, 32'(h_eff));
      end
      w_eff = sb.eff_width();
      h_eff = sb.eff_height();

      case (kind)
        PHASE_PAUSE: begin
          send_pixels($urandom_range(1, w_eff * h_eff - 1), fill);
          pause_until_drained();
          finish_frame(fill);
        end
        PHASE_RECONFIG: begin
          send_pixels($urandom_range(1, w_eff * ((h_eff < 6) ? h_eff : 6) - 1), fill);
          pause_until_drained();
          write_reg(REG_IMAGE_HEIGHT, 32'($urandom_range(0, 6)));
          // Only shrink the width mid-frame so every column read was written
          if ($urandom_range(0, 1)) write_reg(REG_IMAGE_WIDTH, 32'($urandom_range(0, w_eff)));
          finish_frame(fill);
        end
        default: begin
          finish_frame(fill);
        end
      endcase
      pause_until_drained();
    end

    pause_until_drained();
    $display("Checked %0d medians from %0d pixels over %0d frames, %0d register writes.",
             sb.medians_checked, sb.pixels_seen, sb.frames_done, reg_writes);
    $display("Widths 3 to 40, width clamped to 1024, mid-frame resizing and back-pressure covered.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/mf3_pkg.sv
design/mf3_cfg.sv
design/mf3_line_buf.sv
design/mf3_median.sv
design/median_filter_3x3_rgb_top.sv
tb/sv/median_filter_3x3_rgb_top_test.sv
